[rtl/core/sorted_priority_queue_assert.svh]
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int ITEM_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int TOTAL_W = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_PEEK   = 2'd3
  } action_t;

  typedef struct packed {
    logic do_enq;
    logic do_deq;
    logic do_peek;
    logic do_key;
    logic do_drop;
    logic do_done;
  } spq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hit;
  } spq_stat_t;

endpackage

`default_nettype wire

[rtl/core/sorted_priority_queue.sv]
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | action, item_in, priority_in
// output  | out_valid| out_stall | item_out, item_valid, overflow, is_empty, entry_total
//
// Enqueue, dequeue and peek show their result in the next cycle: all slots compare and shift in parallel.
// Remove latches the key, then drops one match per cycle until none is left, then loads the result.
// Outside a remove, a new item is taken while the output register is empty or being drained.
// Reset (synchronous) empties the queue and the output register; no clearing pass.
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [ITEM_W-1:0]  item_in,
  input  wire logic [PRIO_W-1:0]  priority_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ITEM_W-1:0]       item_out,
  output logic                    item_valid,
  output logic                    overflow,
  output logic                    is_empty,
  output logic [TOTAL_W-1:0]      entry_total
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .act      (action_t'(action)),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .item_in     (item_in),
    .priority_in (priority_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .item_out    (item_out),
    .item_valid  (item_valid),
    .overflow    (overflow),
    .is_empty    (is_empty),
    .entry_total (entry_total)
  );

  `SPQ_ASSERT_NEXT(a_remove_busy, clk, rst, in_valid && !in_stall && action == ACT_REMOVE, in_stall)
  `SPQ_ASSERT_NEXT(a_fast_result, clk, rst, in_valid && !in_stall && action != ACT_REMOVE, out_valid)
  `SPQ_ASSERT_SAME(a_ovf_no_item, clk, rst, out_valid && overflow, !item_valid && !is_empty)

endmodule

`default_nettype wire

[rtl/core/spq_ctrl.sv]
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire action_t   act,
  output logic           in_stall,
  input  wire spq_stat_t stat,
  output spq_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          case (act)
            ACT_ENQ:    cmd.do_enq  = 1'b1;
            ACT_DEQ:    cmd.do_deq  = 1'b1;
            ACT_PEEK:   cmd.do_peek = 1'b1;
            ACT_REMOVE: begin
              cmd.do_key = 1'b1;
              state_next = ST_SCAN;
            end
            default:    cmd.do_peek = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // drop the first match each cycle until none is left
        if (stat.hit) begin
          cmd.do_drop = 1'b1;
        end else begin
          cmd.do_done = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/spq_datapath.sv]
`default_nettype none

module spq_datapath
  import spq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spq_cmd_t          cmd,
  output spq_stat_t              stat,
  input  wire logic [ITEM_W-1:0] item_in,
  input  wire logic [PRIO_W-1:0] priority_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ITEM_W-1:0]      item_out,
  output logic                   item_valid,
  output logic                   overflow,
  output logic                   is_empty,
  output logic [TOTAL_W-1:0]     entry_total
);

  logic [ITEM_W-1:0] slot_item     [DEPTH];
  logic [PRIO_W-1:0] slot_priority [DEPTH];
  logic [ITEM_W-1:0] item_nx       [DEPTH];
  logic [PRIO_W-1:0] prio_nx       [DEPTH];
  logic [ITEM_W-1:0] item_dn       [DEPTH];
  logic [PRIO_W-1:0] prio_dn       [DEPTH];
  logic [ITEM_W-1:0] item_up       [DEPTH];
  logic [PRIO_W-1:0] prio_up       [DEPTH];

  logic [CNT_W-1:0]  occupancy;
  logic [CNT_W-1:0]  occupancy_next;
  logic [CNT_W-1:0]  out_count;
  logic [ITEM_W-1:0] key;
  logic [DEPTH-1:0]  ge;
  logic [DEPTH-1:0]  ins;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  past_match;
  logic              full;
  logic              empty;
  logic              load_out;

  assign full     = (occupancy == CNT_W'(DEPTH));
  assign empty    = (occupancy == '0);
  assign load_out = cmd.do_enq || cmd.do_deq || cmd.do_peek || cmd.do_done;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i]    = (CNT_W'(i) < occupancy) && (slot_priority[i] >= priority_in);
      match[i] = (CNT_W'(i) < occupancy) && (slot_item[i] == key);
    end
    ins[0]        = !ge[0];
    past_match[0] = match[0];
    for (int i = 1; i < DEPTH; i++) begin
      ins[i]        = !ge[i] && ge[i-1];
      past_match[i] = past_match[i-1] || match[i];
    end
    item_dn[0] = slot_item[0];
    prio_dn[0] = slot_priority[0];
    for (int i = 1; i < DEPTH; i++) begin
      item_dn[i] = slot_item[i-1];
      prio_dn[i] = slot_priority[i-1];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      item_up[i] = slot_item[i+1];
      prio_up[i] = slot_priority[i+1];
    end
    item_up[DEPTH-1] = slot_item[DEPTH-1];
    prio_up[DEPTH-1] = slot_priority[DEPTH-1];
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      item_nx[i] = slot_item[i];
      prio_nx[i] = slot_priority[i];
      if (cmd.do_enq && !full && !ge[i]) begin
        if (ins[i]) begin
          item_nx[i] = item_in;
          prio_nx[i] = priority_in;
        end else begin
          item_nx[i] = item_dn[i];
          prio_nx[i] = prio_dn[i];
        end
      end else if (cmd.do_deq || (cmd.do_drop && past_match[i])) begin
        item_nx[i] = item_up[i];
        prio_nx[i] = prio_up[i];
      end
    end
  end

  always_comb begin
    occupancy_next = occupancy;
    if (cmd.do_enq && !full) begin
      occupancy_next = occupancy + 1'b1;
    end else if ((cmd.do_deq && !empty) || cmd.do_drop) begin
      occupancy_next = occupancy - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_item[i]     <= item_nx[i];
      slot_priority[i] <= prio_nx[i];
    end
    if (cmd.do_key) begin
      key <= item_in;
    end
    if (load_out) begin
      out_count  <= occupancy_next;
      overflow   <= cmd.do_enq && full;
      item_valid <= (cmd.do_deq || cmd.do_peek) && !empty;
      item_out   <= ((cmd.do_deq || cmd.do_peek) && !empty) ? slot_item[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign is_empty      = (out_count == '0);
  assign entry_total   = TOTAL_W'(out_count);
  assign stat.out_free = !out_valid || !out_stall;
  assign stat.hit      = |match;

endmodule

`default_nettype wire
